// ----- hw/rtl/tcp_connection_table_assert.svh -----
// Assertion macros for the connection table checker
`ifndef TCP_CONNECTION_TABLE_ASSERT_SVH
`define TCP_CONNECTION_TABLE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define TCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define TCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/tct_pkg.sv -----
`default_nettype none
package tct_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   // Tuple as stored in a slot
   typedef struct packed {
      logic [31:0] own_addr;
      logic [31:0] remote_addr;
      logic [31:0] ports;
   } tuple_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_READ  = 2'd1,
      BK_EXEC  = 2'd2,
      BK_WRITE = 2'd3
   } back_state_type;

   // XOR fold of the tuple to 16 bits
   function automatic logic [15:0] fold_tuple(input tuple_type t);
      logic [31:0] w;
      begin
         w = t.own_addr ^ t.remote_addr ^ t.ports;
         fold_tuple = w[31:16] ^ w[15:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tct_front.sv -----
`default_nettype none
// Accept beats, fold the tuple to a bucket index and queue them for the back end
module tct_front
   import tct_pkg::*;
#(
   parameter int DEPTH   = 2,
   parameter int BUCKETS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  cmd,
   input  wire tuple_type   tuple,
   input  wire logic [15:0] handle,
   output logic             q_valid,
   input  wire logic        q_take,
   output logic [1:0]       q_cmd,
   output tuple_type        q_tuple,
   output logic [15:0]      q_handle,
   output logic [15:0]      q_hash
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = 2 + 96 + 16 + 16 + 16;
   // Reciprocal of the bucket count, exact for every 16-bit fold
   localparam int LB = $clog2(BUCKETS);
   localparam int SH = 16 + LB;
   localparam longint unsigned MULW =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [16:0] MUL = 17'(MULW);

   logic [EW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;
   logic [15:0]   fold, quot, m_fold, m_quot;
   logic [32:0]   prod, back_prod;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   // Quotient of the fold by the bucket count
   assign fold = fold_tuple(tuple);
   assign prod = 33'(fold) * 33'(MUL);
   assign quot = 16'(prod >> SH);

   // Bucket index: fold minus quotient times bucket count
   assign {q_cmd, q_tuple, q_handle, m_fold, m_quot} = mem_ff[rp_ff];
   assign back_prod = 33'(m_quot) * 33'(BUCKETS);
   assign q_hash    = m_fold - back_prod[15:0];

   // Advance pointers and count
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (do_pop)  rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= {cmd, tuple, handle, fold, quot};
   end
endmodule
`default_nettype wire

// ----- hw/rtl/tct_back.sv -----
`default_nettype none
// Read a bucket, decide, write back, and hold the result in a one-entry buffer
module tct_back
   import tct_pkg::*;
#(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_take,
   input  wire logic [1:0]  q_cmd,
   input  wire tuple_type   q_tuple,
   input  wire logic [15:0] q_handle,
   input  wire logic [15:0] q_hash,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       status,
   output logic [15:0]      found_handle
);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RW = 96 + 16;

   back_state_type st_ff, st_in;
   logic [WAYS-1:0] valid_ff [BUCKETS];
   logic [RW-1:0]   ram_ff [BUCKETS][WAYS];
   logic [RW-1:0]   rd_ff [WAYS];
   logic [WAYS-1:0] vrd_ff;
   logic [1:0]      cmd_ff;
   tuple_type       tup_ff;
   logic [15:0]     hnd_ff;
   logic [BW-1:0]   bkt_ff;
   logic [BW-1:0]   bkt;
   logic            rsp_ff, rsp_in;
   logic [1:0]      status_ff, status_in;
   logic [15:0]     found_ff, found_in;
   logic            wr_en_ff, wr_en_in;
   logic [WW-1:0]   wr_way_ff, wr_way_in;
   logic [WAYS-1:0] vnew_ff, vnew_in;
   logic            vwr_ff, vwr_in;
   logic            clr_ff, clr_in;
   logic [BW-1:0]   clr_idx_ff, clr_idx_in;

   function automatic logic q_cmd_match(input logic [RW-1:0] e);
      q_cmd_match = (e[RW-1:16] == tup_ff);
   endfunction

   // Bucket index as reduced by the front end
   assign bkt = BW'(q_hash);

   assign empty        = !rsp_ff;
   assign status       = status_ff;
   assign found_handle = found_ff;
   assign q_take       = (st_ff == BK_IDLE) && q_valid && !clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= BK_IDLE;
         rsp_ff <= 1'b0;
         vwr_ff <= 1'b0;
         wr_en_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         st_ff  <= st_in;
         rsp_ff <= rsp_in;
         vwr_ff <= vwr_in;
         wr_en_ff <= wr_en_in;
         clr_ff <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // Sweep one bucket of valid bits per cycle after reset
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + BW'(1);
         if (clr_idx_ff == BW'(BUCKETS-1)) clr_in = 1'b0;
      end
   end

   // Valid bits: cleared by the sweep, updated on write-back
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         valid_ff[clr_idx_ff] <= '0;
      end else if (vwr_ff) begin
         valid_ff[bkt_ff] <= vnew_ff;
      end
   end

   // Slot memory: read a bucket row, write one way
   always_ff @(posedge clock) begin
      if (st_ff == BK_READ) begin
         for (int w = 0; w < WAYS; w++) rd_ff[w] <= ram_ff[bkt_ff][w];
         vrd_ff <= valid_ff[bkt_ff];
      end
      if (wr_en_ff) ram_ff[bkt_ff][wr_way_ff] <= {tup_ff, hnd_ff};
   end

   // Capture the beat
   always_ff @(posedge clock) begin
      if (q_take) begin
         cmd_ff <= q_cmd;
         tup_ff <= q_tuple;
         hnd_ff <= q_handle;
         bkt_ff <= bkt;
      end
      status_ff <= status_in;
      found_ff  <= found_in;
      wr_way_ff <= wr_way_in;
      vnew_ff   <= vnew_in;
   end

   // Compare ways and decide
   always_comb begin
      logic            dup, have_free, hit;
      logic [WW-1:0]   free_w, hit_w;
      logic [15:0]     hit_h;
      dup = 1'b0; have_free = 1'b0; hit = 1'b0;
      free_w = '0; hit_w = '0; hit_h = '0;
      st_in = st_ff;
      rsp_in = rsp_ff;
      status_in = status_ff;
      found_in = found_ff;
      wr_en_in = 1'b0;
      wr_way_in = wr_way_ff;
      vnew_in = vnew_ff;
      vwr_in = 1'b0;
      if (pop && rsp_ff) rsp_in = 1'b0;
      for (int w = WAYS-1; w >= 0; w--) begin
         if (vrd_ff[w]) begin
            if (q_cmd_match(rd_ff[w])) begin
               dup = 1'b1;
            end
            if ((cmd_ff == CMD_LOOKUP && rd_ff[w][RW-1:16] == tup_ff) ||
                (cmd_ff == CMD_REMOVE && rd_ff[w][15:0] == hnd_ff)) begin
               hit = 1'b1; hit_w = WW'(w); hit_h = rd_ff[w][15:0];
            end
         end else begin
            have_free = 1'b1; free_w = WW'(w);
         end
      end
      unique case (st_ff)
         BK_IDLE:  if (q_take) st_in = BK_READ;
         BK_READ:  st_in = BK_EXEC;
         BK_EXEC: begin
            // Wait until the result buffer is free
            if (!rsp_ff || pop) begin
               st_in = BK_IDLE;
               rsp_in = 1'b1;
               found_in = '0;
               status_in = ST_NONE;
               vnew_in = vrd_ff;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (dup) status_in = ST_DUP;
                     else if (!have_free) status_in = ST_FULL;
                     else begin
                        status_in = ST_OK;
                        wr_en_in = 1'b1;
                        wr_way_in = free_w;
                        vnew_in[free_w] = 1'b1;
                        vwr_in = 1'b1;
                        st_in = BK_WRITE;
                     end
                  end
                  CMD_LOOKUP: if (hit) begin
                     status_in = ST_OK; found_in = hit_h;
                  end
                  CMD_REMOVE: if (hit) begin
                     status_in = ST_OK;
                     vnew_in[hit_w] = 1'b0;
                     vwr_in = 1'b1;
                     st_in = BK_WRITE;
                  end
                  default: status_in = ST_NONE;
               endcase
            end
         end
         BK_WRITE: st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- hw/rtl/tcp_connection_table.sv -----
// Connection table: insert, lookup and remove TCP four-tuples in a hashed
// table of BUCKETS buckets by WAYS slots. Each beat gives one result beat.
// An item passes through the back-end states in order: take, bucket read, and
// compare and result; a successful insert or remove then writes its slot or
// valid bits back in a further write state. The result is registered as the
// compare state ends, and a result left waiting stalls the back end until it
// is popped. A two-entry queue lets new beats be taken while one is being
// worked. After reset the valid bits are cleared one bucket per cycle, so no
// beat leaves the queue until the sweep is done.
`default_nettype none
module tcp_connection_table
   import tct_pkg::*;
#(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_local_addr,
   input  wire logic [31:0] req_remote_addr,
   input  wire logic [15:0] req_local_port,
   input  wire logic [15:0] req_remote_port,
   input  wire logic [15:0] req_conn_handle,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_found_handle
);
   tuple_type   tup, q_tuple;
   logic        q_valid, q_take;
   logic [1:0]  q_cmd;
   logic [15:0] q_handle, q_hash;

   assign tup = '{own_addr: req_local_addr, remote_addr: req_remote_addr,
                  ports: {req_local_port, req_remote_port}};

   tct_front #(.DEPTH(2), .BUCKETS(BUCKETS)) u_front (
      .clock, .reset, .push, .full, .cmd(req_command), .tuple(tup),
      .handle(req_conn_handle), .q_valid, .q_take, .q_cmd, .q_tuple,
      .q_handle, .q_hash
   );

   tct_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_cmd, .q_tuple, .q_handle,
      .q_hash, .empty, .pop, .status(rsp_status),
      .found_handle(rsp_found_handle)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/tct_checker.sv -----
`default_nettype none
`include "tcp_connection_table_assert.svh"
// Port-level checks on the connection table
module tct_checker
   import tct_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        push,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_found_handle
);
   // Handle is zero unless status is success
   `TCT_ASSERT_IMPL(a_handle_zero, clock, reset, !empty && rsp_status != ST_OK, rsp_found_handle == 16'd0)
   // A waiting result holds until popped
   `TCT_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_status))
   // Output empty and input not full after reset
   `TCT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty && !full)
endmodule

bind tcp_connection_table tct_checker u_tct_checker (
   .clock, .reset, .push, .full, .empty, .pop, .rsp_status, .rsp_found_handle
);
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tct_pkg::*;

   localparam int BUCKETS = 256;
   localparam int WAYS    = 4;
   localparam int SLOTS   = BUCKETS * WAYS;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] own_addr;
      logic [31:0] remote_addr;
      logic [15:0] own_port;
      logic [15:0] remote_port;
      logic [15:0] conn_handle;
   } conn_req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] found_handle;
   } conn_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [1:0] req_command = '0;
   logic [31:0] req_local_addr = '0, req_remote_addr = '0;
   logic [15:0] req_local_port = '0, req_remote_port = '0, req_conn_handle = '0;
   logic [1:0] rsp_status;
   logic [15:0] rsp_found_handle;

   tcp_connection_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_command(req_command), .req_local_addr(req_local_addr),
      .req_remote_addr(req_remote_addr), .req_local_port(req_local_port),
      .req_remote_port(req_remote_port), .req_conn_handle(req_conn_handle),
      .empty(empty), .pop(pop), .rsp_status(rsp_status),
      .rsp_found_handle(rsp_found_handle)
   );

   always #5 clock = ~clock;

   // shadow copy of the table
   logic        tbl_valid [SLOTS];
   logic [31:0] tbl_laddr [SLOTS];
   logic [31:0] tbl_raddr [SLOTS];
   logic [31:0] tbl_ports [SLOTS];
   logic [15:0] tbl_handle [SLOTS];

   conn_req_type pending_reqs[$];
   conn_rsp_type expected_rsps[$];
   int errors = 0;
   bit stim_done = 1'b0;
   bit hold_sender = 1'b0;
   int send_wait = 0;
   int recv_wait = 0;
   longint cycles = 0;

   // known tuples for well-formed traffic
   conn_req_type live_conns[$];

   function automatic int bucket_index(conn_req_type r);
      logic [31:0] w;
      logic [15:0] f;
      w = r.own_addr ^ r.remote_addr ^ {r.own_port, r.remote_port};
      f = w[31:16] ^ w[15:0];
      return int'(f) % BUCKETS;
   endfunction

   function automatic conn_rsp_type table_apply(conn_req_type r);
      conn_rsp_type res;
      int          base, free_idx;
      logic [31:0] ports;
      bit          dup;
      res = '{status: ST_NONE, found_handle: '0};
      base = bucket_index(r) * WAYS;
      ports = {r.own_port, r.remote_port};
      dup = 1'b0;
      free_idx = -1;
      case (r.command)
         CMD_INSERT: begin
            for (int w = 0; w < WAYS; w++) begin
               if (tbl_valid[base+w]) begin
                  if (tbl_laddr[base+w] == r.own_addr && tbl_raddr[base+w] == r.remote_addr
                      && tbl_ports[base+w] == ports) dup = 1'b1;
               end else if (free_idx < 0) free_idx = base + w;
            end
            if (dup) res.status = ST_DUP;
            else if (free_idx < 0) res.status = ST_FULL;
            else begin
               tbl_valid[free_idx] = 1'b1;
               tbl_laddr[free_idx] = r.own_addr;
               tbl_raddr[free_idx] = r.remote_addr;
               tbl_ports[free_idx] = ports;
               tbl_handle[free_idx] = r.conn_handle;
               res.status = ST_OK;
            end
         end
         CMD_LOOKUP: begin
            for (int w = 0; w < WAYS; w++) begin
               if (res.status != ST_OK && tbl_valid[base+w] && tbl_laddr[base+w] == r.own_addr
                   && tbl_raddr[base+w] == r.remote_addr && tbl_ports[base+w] == ports) begin
                  res.status = ST_OK;
                  res.found_handle = tbl_handle[base+w];
               end
            end
         end
         CMD_REMOVE: begin
            for (int w = 0; w < WAYS; w++) begin
               if (res.status != ST_OK && tbl_valid[base+w]
                   && tbl_handle[base+w] == r.conn_handle) begin
                  tbl_valid[base+w] = 1'b0;
                  res.status = ST_OK;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver: present the next beat, hold it until taken
   always @(posedge clock) begin
      conn_req_type r;
      if (!reset) begin
         if (push && !full) begin
            expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
            send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
         if (!(push && full)) begin
            if (send_wait > 0) begin
               send_wait--;
               push <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
               r = pending_reqs[0];
               push <= 1'b1;
               req_command <= r.command;
               req_local_addr <= r.own_addr;
               req_remote_addr <= r.remote_addr;
               req_local_port <= r.own_port;
               req_remote_port <= r.remote_port;
               req_conn_handle <= r.conn_handle;
            end else push <= 1'b0;
         end
      end
   end

   // monitor: accept result beats and compare with the oldest expectation
   always @(posedge clock) begin
      conn_rsp_type e;
      cycles++;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat status=%0d handle=%0h", rsp_status,
                      rsp_found_handle);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_found_handle !== e.found_handle) begin
                  $error("found_handle expected %0h actual %0h", e.found_handle,
                         rsp_found_handle);
                  errors++;
               end
            end
            recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            pop <= 1'b0;
         end else pop <= 1'b1;
      end
   end

   function automatic conn_req_type rand_req(cmd_type c);
      conn_req_type r;
      r.command = c;
      r.own_addr = $urandom();
      r.remote_addr = $urandom();
      r.own_port = 16'($urandom());
      r.remote_port = 16'($urandom());
      r.conn_handle = 16'($urandom());
      return r;
   endfunction

   // tuple forced into bucket zero: remote_port cancels the low byte of the fold
   function automatic conn_req_type bucket0_req(cmd_type c, logic [15:0] h);
      conn_req_type r;
      logic [31:0] w;
      logic [15:0] f;
      r = rand_req(c);
      r.conn_handle = h;
      r.remote_port = '0;
      w = r.own_addr ^ r.remote_addr ^ {r.own_port, 16'h0};
      f = w[31:16] ^ w[15:0];
      r.remote_port = {8'h0, f[7:0]};
      return r;
   endfunction

   initial begin
      conn_req_type r, b[5];
      int k;
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, full bucket, duplicate, remove by handle
      r = '{CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'hFFFF};
      pending_reqs.push_back(r);
      pending_reqs.push_back(r);
      r.command = CMD_LOOKUP; r.conn_handle = 16'h0; pending_reqs.push_back(r);
      r.command = CMD_UNUSED; pending_reqs.push_back(r);
      r = '{CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'h0};
      pending_reqs.push_back(r);
      r.command = CMD_LOOKUP; pending_reqs.push_back(r);
      for (int i = 0; i < 5; i++) begin
         b[i] = bucket0_req(CMD_INSERT, 16'h100 + 16'(i));
         pending_reqs.push_back(b[i]);
      end
      r = b[1]; r.command = CMD_LOOKUP; pending_reqs.push_back(r);
      // remove matches handle only, tuple differs
      r = b[3]; r.command = CMD_REMOVE; r.own_addr = b[0].own_addr;
      r.remote_addr = b[0].remote_addr; r.own_port = b[0].own_port;
      r.remote_port = b[0].remote_port; pending_reqs.push_back(r);
      pending_reqs.push_back(r);
      r = b[3]; r.command = CMD_LOOKUP; pending_reqs.push_back(r);
      pending_reqs.push_back(b[4]);
      r = b[4]; r.command = CMD_LOOKUP; pending_reqs.push_back(r);
      pending_reqs.push_back(rand_req(CMD_LOOKUP));
      pending_reqs.push_back(rand_req(CMD_REMOVE));

      // pause the sender until the directed part has drained
      wait (pending_reqs.size() == 0);
      hold_sender = 1'b1;
      wait (expected_rsps.size() == 0);
      repeat (8) @(posedge clock);
      hold_sender = 1'b0;

      // random: mostly operations on known tuples, some crowded buckets
      for (int i = 0; i < 1050; i++) begin
         k = $urandom_range(0, 99);
         if (live_conns.size() == 0 || k < 30) begin
            r = (k % 4 == 0) ? bucket0_req(CMD_INSERT, 16'($urandom()))
                              : rand_req(CMD_INSERT);
            if (live_conns.size() > 0 && k < 3) r.conn_handle = live_conns[0].conn_handle;
            live_conns.push_back(r);
            if (live_conns.size() > 64) void'(live_conns.pop_front());
         end else if (k < 90) begin
            r = live_conns[$urandom_range(0, live_conns.size() - 1)];
            case (k % 4)
               0: r.command = CMD_INSERT;
               1: r.command = CMD_LOOKUP;
               default: r.command = CMD_REMOVE;
            endcase
            if (r.command == CMD_LOOKUP) r.conn_handle = 16'($urandom());
         end else r = rand_req(cmd_type'($urandom_range(0, 3)));
         pending_reqs.push_back(r);
      end
      stim_done = 1'b1;
   end

   // end of run
   initial begin
      wait (stim_done && pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("tcp_connection_table: match");
      else $display("tcp_connection_table: mismatch");
      $finish;
   end

   // cycle limit
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tcp_connection_table: mismatch");
         $finish;
      end
   end
endmodule
`default_nettype wire
